FILE: rtl/i2cee_pkg.sv
// Shared constants for the I2C serial EEPROM master: phase codes, command
// codes, configuration register indexes and their reset values.
// No dependencies.
`default_nettype none

package i2cee_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_COUNT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR_VALUE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR_ENABLE = 3'd5;

    // Configuration reset values.
    localparam logic [6:0]  RST_DEVICE_ADDRESS    = 7'd80;
    localparam logic [6:0]  RST_READ_COUNT        = 7'd14;
    localparam logic [15:0] RST_PHASE_TICKS       = 16'd1;
    localparam logic [15:0] RST_ACK_TIMEOUT       = 16'd1000;
    localparam logic [7:0]  RST_TERMINATOR_VALUE  = 8'd13;
    localparam logic        RST_TERMINATOR_ENABLE = 1'b1;

    // Command codes.
    localparam logic [1:0] FUNC_WRITE    = 2'd0;
    localparam logic [1:0] FUNC_RAND_RD  = 2'd1;
    localparam logic [1:0] FUNC_SEQ_RD   = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    // Bus phase codes.
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_DEVW   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_ADDR   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DATA   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_HOLD   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RSTART = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DEVR   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_READ   = 4'd8;
    localparam logic [PHASE_W-1:0] PH_STOP   = 4'd9;

    // Bit slot positions: data bits 0..7, then the acknowledge slot.
    localparam logic [3:0] BIT_LAST_DATA = 4'd7;
    localparam logic [3:0] BIT_ACK       = 4'd8;
    localparam logic [3:0] BIT_FINAL     = 4'd9;

    // Quarters of a bit slot.
    localparam logic [1:0] Q_LOW0  = 2'd0;
    localparam logic [1:0] Q_HIGH0 = 2'd1;
    localparam logic [1:0] Q_HIGH1 = 2'd2;
    localparam logic [1:0] Q_LOW1  = 2'd3;

    // One registered result word.
    typedef struct packed {
        logic       scl_out;
        logic       sda_drive_low;
        logic       busy_res;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       rd_last;
        logic       ack_error;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/i2c_eeprom_master.sv
// I2C serial EEPROM master: one input word is one bus tick with an SDA sample.
// The result word of an accepted input word is registered for the next cycle.
// Throughput: one word per cycle unless a result word is stalled; a tick's
// bus state update is one pass of logic between state and result registers.
// Reset (aresetn low, synchronous): bus idle, counters cleared, configuration
// registers at their defaults, no result word pending.
// Depends on i2cee_pkg.
`default_nettype none

module i2c_eeprom_master #(
    parameter int DIVIDER_WIDTH = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // Configuration write port
    input  wire                               cfg_we,
    input  wire [i2cee_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [i2cee_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input channel
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire                               s_sda_in,
    input  wire                               s_cmd_valid,
    input  wire [1:0]                         s_func,
    input  wire [7:0]                         s_mem_addr,
    input  wire [7:0]                         s_wr_data,
    input  wire                               s_wr_last,
    // Result channel
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic                              m_scl_out,
    output logic                              m_sda_drive_low,
    output logic                              m_busy_res,
    output logic                              m_rd_valid,
    output logic [7:0]                        m_rd_data,
    output logic                              m_rd_last,
    output logic                              m_ack_error
);

    localparam int DW = DIVIDER_WIDTH;
    localparam int EW = (DW > 16) ? DW : 16;
    localparam logic [EW-1:0] DIV_MAX = EW'((64'd1 << DW) - 64'd1);

    // Configuration registers
    logic [6:0]  device_address_reg;
    logic [6:0]  read_count_reg;
    logic [15:0] phase_ticks_reg;
    logic [15:0] ack_timeout_reg;
    logic [7:0]  terminator_value_reg;
    logic        terminator_enable_reg;

    // Bus state
    logic [i2cee_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]    quarter_reg, quarter_next;
    logic [3:0]    bit_count_reg, bit_count_next;
    logic [7:0]    shift_reg, shift_next;
    logic [6:0]    byte_count_reg, byte_count_next;
    logic [DW-1:0] tick_count_reg, tick_count_next;
    logic [DW-1:0] wait_count_reg, wait_count_next;
    logic          write_open_reg, write_open_next;
    logic [7:0]    held_addr_reg, held_addr_next;
    logic [7:0]    held_data_reg, held_data_next;
    logic [1:0]    held_func_reg, held_func_next;

    // Result register
    logic                 m_valid_reg;
    i2cee_pkg::result_t   result_reg, result_next;

    logic          accept;
    logic [EW-1:0] pt_ext, pt_nz, at_ext, at_nz;
    logic [DW-1:0] tick_eff, ack_eff;
    logic [DW:0]   tick_inc, wait_inc;
    logic          is_tx;
    logic          halted;
    logic          last_byte;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Effective timing counts: zero acts as one, capped at the counter range.
    always_comb begin
        pt_ext   = EW'(phase_ticks_reg);
        pt_nz    = (pt_ext == '0) ? EW'(1) : pt_ext;
        tick_eff = (pt_nz > DIV_MAX) ? DIV_MAX[DW-1:0] : pt_nz[DW-1:0];
        at_ext   = EW'(ack_timeout_reg);
        at_nz    = (at_ext == '0) ? EW'(1) : at_ext;
        ack_eff  = (at_nz > DIV_MAX) ? DIV_MAX[DW-1:0] : at_nz[DW-1:0];
    end

    assign tick_inc = {1'b0, tick_count_reg} + (DW+1)'(1);
    assign wait_inc = {1'b0, wait_count_reg} + (DW+1)'(1);
    assign is_tx = (phase_reg == i2cee_pkg::PH_DEVW) || (phase_reg == i2cee_pkg::PH_ADDR)
                || (phase_reg == i2cee_pkg::PH_DATA) || (phase_reg == i2cee_pkg::PH_DEVR);

    // One bus tick: command intake, quarter timing, ACK wait and slot end.
    always_comb begin
        phase_next      = phase_reg;
        quarter_next    = quarter_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        byte_count_next = byte_count_reg;
        tick_count_next = tick_count_reg;
        wait_count_next = wait_count_reg;
        write_open_next = write_open_reg;
        held_addr_next  = held_addr_reg;
        held_data_next  = held_data_reg;
        held_func_next  = held_func_reg;
        halted          = 1'b0;
        last_byte       = 1'b0;
        result_next     = '0;

        if (phase_reg == i2cee_pkg::PH_IDLE) begin
            if (s_cmd_valid && s_func != i2cee_pkg::FUNC_RESERVED) begin
                held_func_next  = s_func;
                held_addr_next  = s_mem_addr;
                held_data_next  = s_wr_data;
                write_open_next = (s_func == i2cee_pkg::FUNC_WRITE) && !s_wr_last;
                phase_next      = i2cee_pkg::PH_START;
                quarter_next    = i2cee_pkg::Q_LOW0;
                bit_count_next  = '0;
                tick_count_next = '0;
                wait_count_next = '0;
                shift_next      = '0;
            end
        end else if (phase_reg == i2cee_pkg::PH_HOLD) begin
            // An open write chain takes only the next data byte.
            if (s_cmd_valid && s_func == i2cee_pkg::FUNC_WRITE) begin
                held_data_next  = s_wr_data;
                write_open_next = !s_wr_last;
                phase_next      = i2cee_pkg::PH_DATA;
                quarter_next    = i2cee_pkg::Q_LOW0;
                bit_count_next  = '0;
                tick_count_next = '0;
                wait_count_next = '0;
                shift_next      = s_wr_data;
            end
        end else if (tick_inc < {1'b0, tick_eff}) begin
            tick_count_next = tick_count_reg + DW'(1);
        end else begin
            tick_count_next = '0;

            // End of the second high quarter: ACK wait and read sampling.
            if (quarter_reg == i2cee_pkg::Q_HIGH1) begin
                if (is_tx && bit_count_reg == i2cee_pkg::BIT_ACK) begin
                    if (s_sda_in) begin
                        halted = 1'b1;
                        if (wait_inc >= {1'b0, ack_eff}) begin
                            result_next.ack_error = 1'b1;
                            write_open_next = 1'b0;
                            phase_next      = i2cee_pkg::PH_STOP;
                            quarter_next    = i2cee_pkg::Q_LOW0;
                            bit_count_next  = '0;
                            tick_count_next = '0;
                            wait_count_next = '0;
                            shift_next      = '0;
                        end else begin
                            wait_count_next = wait_count_reg + DW'(1);
                            tick_count_next = tick_eff - DW'(1);
                        end
                    end else begin
                        wait_count_next = '0;
                    end
                end
                if (!halted && phase_reg == i2cee_pkg::PH_READ
                        && bit_count_reg < i2cee_pkg::BIT_ACK) begin
                    shift_next = {shift_reg[6:0], s_sda_in};
                end
            end

            if (!halted) begin
                if (quarter_reg != i2cee_pkg::Q_LOW1) begin
                    quarter_next = quarter_reg + 2'd1;
                end else begin
                    // End of a bit slot.
                    quarter_next = i2cee_pkg::Q_LOW0;
                    if (phase_reg == i2cee_pkg::PH_START) begin
                        phase_next      = i2cee_pkg::PH_DEVW;
                        bit_count_next  = '0;
                        wait_count_next = '0;
                        shift_next      = {device_address_reg, 1'b0};
                    end else if (phase_reg == i2cee_pkg::PH_RSTART) begin
                        phase_next      = i2cee_pkg::PH_DEVR;
                        bit_count_next  = '0;
                        wait_count_next = '0;
                        shift_next      = {device_address_reg, 1'b1};
                    end else if (phase_reg == i2cee_pkg::PH_STOP) begin
                        phase_next      = i2cee_pkg::PH_IDLE;
                        bit_count_next  = '0;
                        wait_count_next = '0;
                        shift_next      = '0;
                    end else if (is_tx) begin
                        if (bit_count_reg < i2cee_pkg::BIT_ACK) begin
                            shift_next     = {shift_reg[6:0], 1'b0};
                            bit_count_next = bit_count_reg + 4'd1;
                        end else begin
                            bit_count_next  = '0;
                            wait_count_next = '0;
                            shift_next      = '0;
                            unique case (phase_reg)
                                i2cee_pkg::PH_DEVW: begin
                                    phase_next = i2cee_pkg::PH_ADDR;
                                    shift_next = held_addr_reg;
                                end
                                i2cee_pkg::PH_ADDR: begin
                                    if (held_func_reg == i2cee_pkg::FUNC_WRITE) begin
                                        phase_next = i2cee_pkg::PH_DATA;
                                        shift_next = held_data_reg;
                                    end else begin
                                        phase_next = i2cee_pkg::PH_RSTART;
                                    end
                                end
                                i2cee_pkg::PH_DATA: begin
                                    phase_next = write_open_reg ? i2cee_pkg::PH_HOLD
                                                                : i2cee_pkg::PH_STOP;
                                end
                                default: begin
                                    phase_next      = i2cee_pkg::PH_READ;
                                    byte_count_next = '0;
                                end
                            endcase
                        end
                    end else if (phase_reg == i2cee_pkg::PH_READ) begin
                        if (bit_count_reg < i2cee_pkg::BIT_LAST_DATA) begin
                            bit_count_next = bit_count_reg + 4'd1;
                        end else if (bit_count_reg == i2cee_pkg::BIT_LAST_DATA) begin
                            last_byte = (held_func_reg != i2cee_pkg::FUNC_SEQ_RD)
                                || ({1'b0, byte_count_reg} + 8'd1 >= {1'b0, read_count_reg})
                                || (terminator_enable_reg
                                    && shift_reg == terminator_value_reg);
                            result_next.rd_valid = 1'b1;
                            result_next.rd_data  = shift_reg;
                            result_next.rd_last  = last_byte;
                            bit_count_next = last_byte ? i2cee_pkg::BIT_FINAL
                                                       : i2cee_pkg::BIT_ACK;
                        end else if (bit_count_reg == i2cee_pkg::BIT_ACK) begin
                            byte_count_next = byte_count_reg + 7'd1;
                            bit_count_next  = '0;
                        end else begin
                            phase_next      = i2cee_pkg::PH_STOP;
                            bit_count_next  = '0;
                            wait_count_next = '0;
                            shift_next      = '0;
                        end
                    end
                end
            end
        end

        // Bus levels from the updated state.
        result_next.busy_res = (phase_next != i2cee_pkg::PH_IDLE);
        unique case (phase_next)
            i2cee_pkg::PH_IDLE: begin
                result_next.scl_out       = 1'b1;
                result_next.sda_drive_low = 1'b0;
            end
            i2cee_pkg::PH_HOLD: begin
                result_next.scl_out       = 1'b0;
                result_next.sda_drive_low = 1'b0;
            end
            i2cee_pkg::PH_START, i2cee_pkg::PH_RSTART: begin
                result_next.scl_out = (quarter_next == i2cee_pkg::Q_HIGH0)
                    || (quarter_next == i2cee_pkg::Q_HIGH1)
                    || (quarter_next == i2cee_pkg::Q_LOW0 && phase_next == i2cee_pkg::PH_START);
                result_next.sda_drive_low = quarter_next[1];
            end
            i2cee_pkg::PH_STOP: begin
                result_next.scl_out       = (quarter_next != i2cee_pkg::Q_LOW0);
                result_next.sda_drive_low = !quarter_next[1];
            end
            i2cee_pkg::PH_READ: begin
                result_next.scl_out = (quarter_next == i2cee_pkg::Q_HIGH0)
                                   || (quarter_next == i2cee_pkg::Q_HIGH1);
                result_next.sda_drive_low = (bit_count_next == i2cee_pkg::BIT_ACK);
            end
            default: begin
                result_next.scl_out = (quarter_next == i2cee_pkg::Q_HIGH0)
                                   || (quarter_next == i2cee_pkg::Q_HIGH1);
                result_next.sda_drive_low = (bit_count_next < i2cee_pkg::BIT_ACK)
                                         && !shift_next[7];
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg    <= i2cee_pkg::RST_DEVICE_ADDRESS;
            read_count_reg        <= i2cee_pkg::RST_READ_COUNT;
            phase_ticks_reg       <= i2cee_pkg::RST_PHASE_TICKS;
            ack_timeout_reg       <= i2cee_pkg::RST_ACK_TIMEOUT;
            terminator_value_reg  <= i2cee_pkg::RST_TERMINATOR_VALUE;
            terminator_enable_reg <= i2cee_pkg::RST_TERMINATOR_ENABLE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                i2cee_pkg::CFG_DEVICE_ADDRESS:    device_address_reg    <= cfg_wdata[6:0];
                i2cee_pkg::CFG_READ_COUNT:        read_count_reg        <= cfg_wdata[6:0];
                i2cee_pkg::CFG_PHASE_TICKS:       phase_ticks_reg       <= cfg_wdata;
                i2cee_pkg::CFG_ACK_TIMEOUT:       ack_timeout_reg       <= cfg_wdata;
                i2cee_pkg::CFG_TERMINATOR_VALUE:  terminator_value_reg  <= cfg_wdata[7:0];
                i2cee_pkg::CFG_TERMINATOR_ENABLE: terminator_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Bus state advances once per accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= i2cee_pkg::PH_IDLE;
            quarter_reg    <= i2cee_pkg::Q_LOW0;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            byte_count_reg <= '0;
            tick_count_reg <= '0;
            wait_count_reg <= '0;
            write_open_reg <= 1'b0;
            held_addr_reg  <= '0;
            held_data_reg  <= '0;
            held_func_reg  <= '0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            quarter_reg    <= quarter_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            byte_count_reg <= byte_count_next;
            tick_count_reg <= tick_count_next;
            wait_count_reg <= wait_count_next;
            write_open_reg <= write_open_next;
            held_addr_reg  <= held_addr_next;
            held_data_reg  <= held_data_next;
            held_func_reg  <= held_func_next;
        end
    end

    // Result register: valid flag is control, the word itself is payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_scl_out       = result_reg.scl_out;
    assign m_sda_drive_low = result_reg.sda_drive_low;
    assign m_busy_res      = result_reg.busy_res;
    assign m_rd_valid      = result_reg.rd_valid;
    assign m_rd_data       = result_reg.rd_data;
    assign m_rd_last       = result_reg.rd_last;
    assign m_ack_error     = result_reg.ack_error;

endmodule

`default_nettype wire

FILE: rtl/i2c_eeprom_master_chk.sv
// Port-level checker for the I2C serial EEPROM master, bound to the top level.
// Depends only on the ports of i2c_eeprom_master.
`default_nettype none

module i2c_eeprom_master_chk (
    input wire       aclk,
    input wire       aresetn,
    input wire       m_valid,
    input wire       m_ready,
    input wire       m_scl_out,
    input wire       m_sda_drive_low,
    input wire       m_busy_res,
    input wire       m_rd_valid,
    input wire [7:0] m_rd_data,
    input wire       m_rd_last
);

    // No result word is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word pending after reset");

    // A stalled result word keeps its read byte.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rd_data) && $stable(m_rd_valid))
        else $error("stalled result word changed");

    // An idle bus shows SCL released and SDA released.
    a_idle_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> m_scl_out && !m_sda_drive_low)
        else $error("idle bus levels wrong");

    // Without a delivered byte the read fields stay zero, and a byte comes mid-transfer.
    a_read_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rd_valid ? m_busy_res : (m_rd_data == 8'd0 && !m_rd_last)))
        else $error("read fields inconsistent");

endmodule

bind i2c_eeprom_master i2c_eeprom_master_chk u_chk (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_scl_out       (m_scl_out),
    .m_sda_drive_low (m_sda_drive_low),
    .m_busy_res      (m_busy_res),
    .m_rd_valid      (m_rd_valid),
    .m_rd_data       (m_rd_data),
    .m_rd_last       (m_rd_last)
);

`default_nettype wire

FILE: bench/tb_i2c_eeprom_master.sv
// Self-checking bench for the I2C serial EEPROM master: one word is one bus tick.
// A cycle-exact bus model predicts every result word; an EEPROM-like responder
// shapes the SDA samples. Depends on i2cee_pkg and i2c_eeprom_master.
`timescale 1ns / 100ps

module tb_i2c_eeprom_master;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned NO_CAP      = 32'hFFFF_FFFF;

    // Bus tick model: own copy of the registers and the bus state, plus the
    // result words still owed by the block.
    class eeprom_bus_model_t;
        logic [6:0]                    dev_addr;
        logic [6:0]                    rd_count;
        logic [15:0]                   quarter_ticks;
        logic [15:0]                   ack_limit;
        logic [7:0]                    term_value;
        logic                          term_enable;
        logic [i2cee_pkg::PHASE_W-1:0] phase;
        logic [1:0]                    quarter;
        logic [3:0]                    bit_cnt;
        logic [7:0]                    shreg;
        logic [6:0]                    byte_cnt;
        int unsigned                   tick_cnt;
        int unsigned                   wait_cnt;
        logic                          chain_open;
        logic [7:0]                    held_addr;
        logic [7:0]                    held_data;
        logic [1:0]                    held_func;
        i2cee_pkg::result_t            res;
        i2cee_pkg::result_t            words_due[$];
        int unsigned                   mismatches;
        int unsigned                   cmds_taken;
        int unsigned                   words_seen;

        function new();
            mismatches = 0;
            cmds_taken = 0;
            words_seen = 0;
            reset_state();
        endfunction

        function void reset_state();
            dev_addr      = i2cee_pkg::RST_DEVICE_ADDRESS;
            rd_count      = i2cee_pkg::RST_READ_COUNT;
            quarter_ticks = i2cee_pkg::RST_PHASE_TICKS;
            ack_limit     = i2cee_pkg::RST_ACK_TIMEOUT;
            term_value    = i2cee_pkg::RST_TERMINATOR_VALUE;
            term_enable   = i2cee_pkg::RST_TERMINATOR_ENABLE;
            enter_phase(i2cee_pkg::PH_IDLE, 8'd0);
            byte_cnt   = 7'd0;
            chain_open = 1'b0;
            held_addr  = 8'd0;
            held_data  = 8'd0;
            held_func  = i2cee_pkg::FUNC_WRITE;
            words_due.delete();
        endfunction

        // Register writes keep only the bits that each register holds.
        function void write_reg(input logic [i2cee_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] value);
            case (idx)
                i2cee_pkg::CFG_DEVICE_ADDRESS:    dev_addr = value[6:0];
                i2cee_pkg::CFG_READ_COUNT:        rd_count = value[6:0];
                i2cee_pkg::CFG_PHASE_TICKS:       quarter_ticks = value;
                i2cee_pkg::CFG_ACK_TIMEOUT:       ack_limit = value;
                i2cee_pkg::CFG_TERMINATOR_VALUE:  term_value = value[7:0];
                i2cee_pkg::CFG_TERMINATOR_ENABLE: term_enable = value[0];
                default: ;
            endcase
        endfunction

        // A zero count behaves as one; 16-bit values never exceed the divider.
        function int unsigned clip_count(input logic [15:0] v);
            return (v == 16'd0) ? 1 : {16'd0, v};
        endfunction

        function bit is_tx();
            return phase == i2cee_pkg::PH_DEVW || phase == i2cee_pkg::PH_ADDR
                || phase == i2cee_pkg::PH_DATA || phase == i2cee_pkg::PH_DEVR;
        endfunction

        function void enter_phase(input logic [i2cee_pkg::PHASE_W-1:0] ph,
                                  input logic [7:0] load);
            phase    = ph;
            quarter  = i2cee_pkg::Q_LOW0;
            bit_cnt  = 4'd0;
            tick_cnt = 0;
            wait_cnt = 0;
            shreg    = load;
        endfunction

        // End of a bit slot: move to the next bit or the next phase.
        function void slot_end();
            int unsigned next_count;
            bit          last_byte;
            if (phase == i2cee_pkg::PH_START) begin
                enter_phase(i2cee_pkg::PH_DEVW, {dev_addr, 1'b0});
            end else if (phase == i2cee_pkg::PH_RSTART) begin
                enter_phase(i2cee_pkg::PH_DEVR, {dev_addr, 1'b1});
            end else if (phase == i2cee_pkg::PH_STOP) begin
                enter_phase(i2cee_pkg::PH_IDLE, 8'd0);
            end else if (is_tx()) begin
                if (bit_cnt < i2cee_pkg::BIT_ACK) begin
                    shreg = shreg << 1;
                    bit_cnt = bit_cnt + 4'd1;
                end else if (phase == i2cee_pkg::PH_DEVW) begin
                    enter_phase(i2cee_pkg::PH_ADDR, held_addr);
                end else if (phase == i2cee_pkg::PH_ADDR) begin
                    if (held_func == i2cee_pkg::FUNC_WRITE)
                        enter_phase(i2cee_pkg::PH_DATA, held_data);
                    else
                        enter_phase(i2cee_pkg::PH_RSTART, 8'd0);
                end else if (phase == i2cee_pkg::PH_DATA) begin
                    enter_phase(chain_open ? i2cee_pkg::PH_HOLD : i2cee_pkg::PH_STOP, 8'd0);
                end else begin
                    enter_phase(i2cee_pkg::PH_READ, 8'd0);
                    byte_cnt = 7'd0;
                end
            end else if (phase == i2cee_pkg::PH_READ) begin
                if (bit_cnt < i2cee_pkg::BIT_LAST_DATA) begin
                    bit_cnt = bit_cnt + 4'd1;
                end else if (bit_cnt == i2cee_pkg::BIT_LAST_DATA) begin
                    // The byte is complete: deliver it and pick ACK or NACK.
                    next_count = byte_cnt + 1;
                    last_byte = (held_func != i2cee_pkg::FUNC_SEQ_RD)
                        || (next_count >= rd_count)
                        || (term_enable && shreg == term_value);
                    res.rd_valid = 1'b1;
                    res.rd_data  = shreg;
                    res.rd_last  = last_byte;
                    bit_cnt = last_byte ? i2cee_pkg::BIT_FINAL : i2cee_pkg::BIT_ACK;
                end else if (bit_cnt == i2cee_pkg::BIT_ACK) begin
                    byte_cnt = byte_cnt + 7'd1;
                    bit_cnt = 4'd0;
                end else begin
                    enter_phase(i2cee_pkg::PH_STOP, 8'd0);
                end
            end
        endfunction

        // One tick of the quarter divider, with the SDA sample.
        function void advance(input logic sda);
            int unsigned span;
            span = clip_count(quarter_ticks);
            if (tick_cnt + 1 < span) begin
                tick_cnt++;
                return;
            end
            tick_cnt = 0;
            if (quarter == i2cee_pkg::Q_HIGH1) begin
                if (is_tx() && bit_cnt == i2cee_pkg::BIT_ACK) begin
                    // SCL stays high until the slave pulls SDA low or time runs out.
                    if (sda) begin
                        wait_cnt++;
                        if (wait_cnt >= clip_count(ack_limit)) begin
                            res.ack_error = 1'b1;
                            chain_open = 1'b0;
                            enter_phase(i2cee_pkg::PH_STOP, 8'd0);
                        end else begin
                            tick_cnt = span - 1;
                        end
                        return;
                    end
                    wait_cnt = 0;
                end
                if (phase == i2cee_pkg::PH_READ && bit_cnt < i2cee_pkg::BIT_ACK)
                    shreg = {shreg[6:0], sda};
            end
            if (quarter < i2cee_pkg::Q_LOW1) begin
                quarter = quarter + 2'd1;
                return;
            end
            quarter = i2cee_pkg::Q_LOW0;
            slot_end();
        endfunction

        // An accepted input word: work out the result word that it causes.
        function void note_tick(input logic sda, input logic cv, input logic [1:0] fn,
                                input logic [7:0] ma, input logic [7:0] wd, input logic wl);
            res = '0;
            if (phase == i2cee_pkg::PH_IDLE) begin
                if (cv && fn != i2cee_pkg::FUNC_RESERVED) begin
                    held_func  = fn;
                    held_addr  = ma;
                    held_data  = wd;
                    chain_open = (fn == i2cee_pkg::FUNC_WRITE) && !wl;
                    enter_phase(i2cee_pkg::PH_START, 8'd0);
                    cmds_taken++;
                end
            end else if (phase == i2cee_pkg::PH_HOLD) begin
                if (cv && fn == i2cee_pkg::FUNC_WRITE) begin
                    held_data  = wd;
                    chain_open = !wl;
                    enter_phase(i2cee_pkg::PH_DATA, wd);
                    cmds_taken++;
                end
            end else begin
                advance(sda);
            end

            // Bus levels follow the phase and the quarter.
            case (phase)
                i2cee_pkg::PH_IDLE: begin
                    res.scl_out = 1'b1;
                    res.sda_drive_low = 1'b0;
                end
                i2cee_pkg::PH_HOLD: begin
                    res.scl_out = 1'b0;
                    res.sda_drive_low = 1'b0;
                end
                i2cee_pkg::PH_START, i2cee_pkg::PH_RSTART: begin
                    res.scl_out = quarter == i2cee_pkg::Q_HIGH0
                        || quarter == i2cee_pkg::Q_HIGH1
                        || (quarter == i2cee_pkg::Q_LOW0 && phase == i2cee_pkg::PH_START);
                    res.sda_drive_low = quarter >= i2cee_pkg::Q_HIGH1;
                end
                i2cee_pkg::PH_STOP: begin
                    res.scl_out = quarter != i2cee_pkg::Q_LOW0;
                    res.sda_drive_low = quarter < i2cee_pkg::Q_HIGH1;
                end
                i2cee_pkg::PH_READ: begin
                    res.scl_out = quarter == i2cee_pkg::Q_HIGH0
                        || quarter == i2cee_pkg::Q_HIGH1;
                    res.sda_drive_low = bit_cnt == i2cee_pkg::BIT_ACK;
                end
                default: begin
                    res.scl_out = quarter == i2cee_pkg::Q_HIGH0
                        || quarter == i2cee_pkg::Q_HIGH1;
                    res.sda_drive_low = bit_cnt < i2cee_pkg::BIT_ACK && !shreg[7];
                end
            endcase
            res.busy_res = phase != i2cee_pkg::PH_IDLE;
            words_due.push_back(res);
        endfunction

        task report_mismatch(input string field, input logic [7:0] got_v,
                             input logic [7:0] want_v);
            $display("MISMATCH word %0d %s: got %0h, expected %0h",
                     words_seen, field, got_v, want_v);
            mismatches++;
        endtask

        // An accepted result word against the oldest expected one.
        task check_tick(input i2cee_pkg::result_t got);
            i2cee_pkg::result_t want;
            if (words_due.size() == 0) begin
                report_mismatch("unexpected word", 8'd0, 8'd0);
            end else begin
                want = words_due.pop_front();
                if (got.scl_out !== want.scl_out)
                    report_mismatch("scl_out", {7'd0, got.scl_out}, {7'd0, want.scl_out});
                if (got.sda_drive_low !== want.sda_drive_low)
                    report_mismatch("sda_drive_low", {7'd0, got.sda_drive_low},
                                    {7'd0, want.sda_drive_low});
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", {7'd0, got.busy_res}, {7'd0, want.busy_res});
                if (got.rd_valid !== want.rd_valid)
                    report_mismatch("rd_valid", {7'd0, got.rd_valid}, {7'd0, want.rd_valid});
                if (got.rd_data !== want.rd_data)
                    report_mismatch("rd_data", got.rd_data, want.rd_data);
                if (got.rd_last !== want.rd_last)
                    report_mismatch("rd_last", {7'd0, got.rd_last}, {7'd0, want.rd_last});
                if (got.ack_error !== want.ack_error)
                    report_mismatch("ack_error", {7'd0, got.ack_error},
                                    {7'd0, want.ack_error});
            end
            words_seen++;
        endtask
    endclass

    typedef struct {
        logic [1:0] fn;
        logic [7:0] addr;
        logic [7:0] data;
        logic       last;
    } bus_cmd_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [i2cee_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]                     cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    logic                            s_sda_in = 1'b1;
    logic                            s_cmd_valid = 1'b0;
    logic [1:0]                      s_func = i2cee_pkg::FUNC_WRITE;
    logic [7:0]                      s_mem_addr = 8'd0;
    logic [7:0]                      s_wr_data = 8'd0;
    logic                            s_wr_last = 1'b0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    logic                            m_scl_out;
    logic                            m_sda_drive_low;
    logic                            m_busy_res;
    logic                            m_rd_valid;
    logic [7:0]                      m_rd_data;
    logic                            m_rd_last;
    logic                            m_ack_error;

    eeprom_bus_model_t bus_model;
    bus_cmd_t          cmd_plan[$];
    logic [7:0]        slave_byte = 8'd0;
    bit                nack_all = 1'b0;
    bit                hold_off_due = 1'b0;
    logic [15:0]       rx_pattern = 16'hFFFF;
    logic [7:0]        rx_step = 8'd0;
    int unsigned       quiet_cycles = 0;

    i2c_eeprom_master dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sda_in        (s_sda_in),
        .s_cmd_valid     (s_cmd_valid),
        .s_func          (s_func),
        .s_mem_addr      (s_mem_addr),
        .s_wr_data       (s_wr_data),
        .s_wr_last       (s_wr_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scl_out       (m_scl_out),
        .m_sda_drive_low (m_sda_drive_low),
        .m_busy_res      (m_busy_res),
        .m_rd_valid      (m_rd_valid),
        .m_rd_data       (m_rd_data),
        .m_rd_last       (m_rd_last),
        .m_ack_error     (m_ack_error)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: check each accepted word, stall on a rotating pattern.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            bus_model.check_tick({m_scl_out, m_sda_drive_low, m_busy_res, m_rd_valid,
                                  m_rd_data, m_rd_last, m_ack_error});
        rx_step <= rx_step + 8'd1;
        if (rx_step == 8'hFF)
            rx_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                          : (16'($urandom_range(0, 65535)) | 16'h0101);
        m_ready <= rx_pattern[rx_step[3:0]];
    end

    // Watchdog: too long without any word moving on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] with_junk(input logic [15:0] v, input int unsigned w);
        logic [15:0] r;
        r = 16'($urandom_range(0, 65535));
        return (w >= 16) ? v : (v | (r << w));
    endfunction

    function automatic void plan_cmd(input logic [1:0] fn, input logic [7:0] addr,
                                     input logic [7:0] data, input logic last);
        bus_cmd_t c;
        c.fn = fn;
        c.addr = addr;
        c.data = data;
        c.last = last;
        cmd_plan.push_back(c);
    endfunction

    task automatic write_reg(input logic [i2cee_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        bus_model.write_reg(idx, value);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Registers change only once every owed word is back and the block is quiet.
    task automatic apply_settings(input logic [6:0] dev, input logic [6:0] rcount,
                                  input logic [15:0] qticks, input logic [15:0] ackto,
                                  input logic [7:0] tval, input logic ten);
        while (bus_model.words_due.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        write_reg(i2cee_pkg::CFG_DEVICE_ADDRESS, with_junk({9'd0, dev}, 7));
        write_reg(i2cee_pkg::CFG_READ_COUNT, with_junk({9'd0, rcount}, 7));
        write_reg(i2cee_pkg::CFG_PHASE_TICKS, qticks);
        write_reg(i2cee_pkg::CFG_ACK_TIMEOUT, ackto);
        write_reg(i2cee_pkg::CFG_TERMINATOR_VALUE, with_junk({8'd0, tval}, 8));
        write_reg(i2cee_pkg::CFG_TERMINATOR_ENABLE, with_junk({15'd0, ten}, 1));
    endtask

    // Next input word. SDA plays an EEPROM: ACKs with some delay and shifts
    // out bytes, now and then the terminator, with a little noise.
    task automatic offer_tick(input bit allow_cmds);
        logic        sda;
        logic        cv;
        logic [1:0]  fn;
        logic [7:0]  ma;
        logic [7:0]  wd;
        logic        wl;
        int unsigned pick;
        bus_cmd_t    c;
        if (bus_model.is_tx() && bus_model.bit_cnt == i2cee_pkg::BIT_ACK) begin
            sda = nack_all ? 1'b1 : ($urandom_range(0, 3) == 0);
        end else if (bus_model.phase == i2cee_pkg::PH_READ
                     && bus_model.bit_cnt < i2cee_pkg::BIT_ACK) begin
            sda = slave_byte[3'd7 - bus_model.bit_cnt[2:0]];
            if ($urandom_range(0, 15) == 0) sda = !sda;
        end else begin
            sda = 1'($urandom_range(0, 1));
            slave_byte = ($urandom_range(0, 4) == 0) ? bus_model.term_value
                         : 8'($urandom_range(0, 255));
        end

        cv = 1'b0;
        fn = 2'($urandom_range(0, 3));
        ma = 8'($urandom_range(0, 255));
        wd = 8'($urandom_range(0, 255));
        wl = 1'($urandom_range(0, 1));
        if (bus_model.phase == i2cee_pkg::PH_IDLE || bus_model.phase == i2cee_pkg::PH_HOLD) begin
            if (!allow_cmds) begin
                // Close an open chain so that the bus can go idle.
                cv = bus_model.phase == i2cee_pkg::PH_HOLD;
                fn = i2cee_pkg::FUNC_WRITE;
                wl = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                cv = 1'b1;
                if (cmd_plan.size() != 0) begin
                    c = cmd_plan.pop_front();
                    fn = c.fn;
                    ma = c.addr;
                    wd = c.data;
                    wl = c.last;
                end else if (bus_model.phase == i2cee_pkg::PH_HOLD) begin
                    if ($urandom_range(0, 4) != 0) fn = i2cee_pkg::FUNC_WRITE;
                    wl = $urandom_range(0, 2) == 0;
                end else begin
                    pick = $urandom_range(0, 9);
                    fn = (pick < 4) ? i2cee_pkg::FUNC_WRITE
                         : (pick < 6) ? i2cee_pkg::FUNC_RAND_RD
                         : (pick < 9) ? i2cee_pkg::FUNC_SEQ_RD : i2cee_pkg::FUNC_RESERVED;
                end
            end
        end else begin
            // Commands while busy are ignored by the block.
            cv = $urandom_range(0, 7) == 0;
        end
        s_sda_in <= sda;
        s_cmd_valid <= cv;
        s_func <= fn;
        s_mem_addr <= ma;
        s_wr_data <= wd;
        s_wr_last <= wl;
    endtask

    // Send words in bursts until the command goal is met and the bus is idle,
    // or until the tick cap is reached.
    task automatic run_traffic(input int unsigned cmd_goal, input int unsigned tick_cap,
                               input bit gappy);
        int unsigned goal_mark;
        int unsigned ticks;
        int unsigned burst_left;
        int unsigned gap_left;
        bit          drain_wait;
        bit          done;
        goal_mark = bus_model.cmds_taken + cmd_goal;
        ticks = 0;
        burst_left = $urandom_range(1, 40);
        gap_left = 0;
        drain_wait = 1'b0;
        done = 1'b0;
        while (!done) begin
            @(posedge aclk);
            if (s_valid && s_ready) begin
                bus_model.note_tick(s_sda_in, s_cmd_valid, s_func, s_mem_addr,
                                    s_wr_data, s_wr_last);
                ticks++;
            end
            if (hold_off_due && ticks >= 150) begin
                hold_off_due = 1'b0;
                drain_wait = 1'b1;
            end
            if (!s_valid || s_ready) begin
                if ((bus_model.cmds_taken >= goal_mark
                        && bus_model.phase == i2cee_pkg::PH_IDLE)
                    || ticks >= tick_cap) begin
                    s_valid <= 1'b0;
                    done = 1'b1;
                end else if (drain_wait) begin
                    // Hold off until every owed word has come back.
                    s_valid <= 1'b0;
                    if (bus_model.words_due.size() == 0) drain_wait = 1'b0;
                end else if (gap_left != 0) begin
                    s_valid <= 1'b0;
                    gap_left--;
                end else begin
                    offer_tick(bus_model.cmds_taken < goal_mark);
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = gappy ? $urandom_range(0, 6) : 0;
                    end
                end
            end
        end
        cmd_plan.delete();
    endtask

    initial begin
        bus_model = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: ignored code, field extremes, a chain with an
        // ignored read inside it, both reads.
        hold_off_due = 1'b1;
        plan_cmd(i2cee_pkg::FUNC_RESERVED, 8'hFF, 8'hFF, 1'b1);
        plan_cmd(i2cee_pkg::FUNC_WRITE, 8'h00, 8'h00, 1'b1);
        plan_cmd(i2cee_pkg::FUNC_WRITE, 8'hFF, 8'hFF, 1'b0);
        plan_cmd(i2cee_pkg::FUNC_RAND_RD, 8'h12, 8'h34, 1'b1);
        plan_cmd(i2cee_pkg::FUNC_WRITE, 8'h00, 8'h5A, 1'b0);
        plan_cmd(i2cee_pkg::FUNC_WRITE, 8'h00, 8'hA5, 1'b1);
        plan_cmd(i2cee_pkg::FUNC_RAND_RD, 8'h80, 8'h00, 1'b0);
        plan_cmd(i2cee_pkg::FUNC_SEQ_RD, 8'hFF, 8'h00, 1'b1);
        run_traffic(6, NO_CAP, 1'b1);

        // Zero in every register: zero counts act as one.
        apply_settings(7'd0, 7'd0, 16'd0, 16'd0, 8'd0, 1'b0);
        plan_cmd(i2cee_pkg::FUNC_WRITE, 8'h00, 8'hFF, 1'b1);
        plan_cmd(i2cee_pkg::FUNC_SEQ_RD, 8'h00, 8'h00, 1'b0);
        run_traffic(2, NO_CAP, 1'b0);

        // Top values: all-ones device address and terminator, longest timeout.
        apply_settings(7'd127, 7'd2, 16'd1, 16'd65535, 8'hFF, 1'b1);
        plan_cmd(i2cee_pkg::FUNC_SEQ_RD, 8'h7F, 8'h00, 1'b0);
        run_traffic(1, NO_CAP, 1'b1);

        // A silent slave: every ACK wait times out, an open chain is closed.
        apply_settings(i2cee_pkg::RST_DEVICE_ADDRESS, i2cee_pkg::RST_READ_COUNT, 16'd2, 16'd3,
                       8'd13, 1'b1);
        nack_all = 1'b1;
        plan_cmd(i2cee_pkg::FUNC_WRITE, 8'h00, 8'h00, 1'b0);
        plan_cmd(i2cee_pkg::FUNC_RAND_RD, 8'h00, 8'h00, 1'b0);
        run_traffic(2, NO_CAP, 1'b0);
        nack_all = 1'b0;

        // Random traffic under random settings.
        apply_settings(7'($urandom_range(0, 127)), 7'($urandom_range(1, 2)), 16'd1,
                       16'($urandom_range(2, 4)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        run_traffic(1, NO_CAP, 1'b1);

        // Slowest divider: run partway into the first quarter of a start slot.
        apply_settings(7'($urandom_range(0, 127)), i2cee_pkg::RST_READ_COUNT, 16'd65535,
                       16'd65535, i2cee_pkg::RST_TERMINATOR_VALUE, 1'b1);
        run_traffic(1, 60, 1'b1);

        while (bus_model.words_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (bus_model.mismatches == 0 && bus_model.words_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: i2c_eeprom_master.f
rtl/i2cee_pkg.sv
rtl/i2c_eeprom_master.sv
rtl/i2c_eeprom_master_chk.sv
bench/tb_i2c_eeprom_master.sv
